// File: hw/rtl/visual_align_p_controller_assert.svh
// assertion macros shared by the alignment controller rtl
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef VISUAL_ALIGN_P_CONTROLLER_ASSERT_SVH
`define VISUAL_ALIGN_P_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS
`define VAP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("vap assertion failed");
`define VAP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("vap assertion failed");
`else
`define VAP_ASSERT(lbl, clk, rstn, prop)
`define VAP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: hw/rtl/vap_pkg.sv
// types, codes and constants of the alignment controller
// used by vap_in_if, the axis unit and the top level
package vap_pkg;

  localparam int ErrBits = 12;
  localparam int DzBits  = 11;
  localparam int CmpW    = (ErrBits > DzBits) ? ErrBits : DzBits;
  localparam int ProdW   = ErrBits + 16;
  localparam int AddrW   = 5;

  typedef enum logic [1:0] {
    OpMeas  = 2'd0,
    OpTick  = 2'd1,
    OpStart = 2'd2,
    OpStop  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    RegGain    = 3'd0,
    RegDeadZn  = 3'd1,
    RegMaxSpd  = 3'd2,
    RegWarmup  = 3'd3,
    RegTimeout = 3'd4
  } reg_e;

  localparam logic [1:0]  LostCode   = 2'd2;
  localparam logic [15:0] GainRst    = 16'd256;
  localparam logic [10:0] DeadZnRst  = 11'd10;
  localparam logic [6:0]  MaxSpdRst  = 7'd30;
  localparam logic [7:0]  WarmupRst  = 8'd10;
  localparam int          TimeoutMs  = 15000;
  localparam int          TickMs     = 50;
  localparam logic [15:0] TimeoutRst = 16'(TimeoutMs / TickMs);
  localparam logic [7:0]  CountMax   = 8'hff;
  localparam logic [15:0] TickMax    = 16'hffff;

  typedef struct packed {
    logic [15:0]       gain_q8;
    logic [DzBits-1:0] dead_zone;
    logic [6:0]        max_speed;
    logic [7:0]        warmup_updates;
    logic [15:0]       timeout_ticks;
  } cfg_t;

endpackage

// File: hw/rtl/vap_if.sv
// request channels of the alignment controller: measurement/command in, velocity out
// depends on vap_pkg
interface vap_in_if;
  import vap_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [1:0]                opcode;
  logic signed [ErrBits-1:0] err_x;
  logic signed [ErrBits-1:0] err_y;
  logic [1:0]                dir_x;
  logic [1:0]                dir_y;

  modport source (output valid, opcode, err_x, err_y, dir_x, dir_y, input ready);
  modport sink (input valid, opcode, err_x, err_y, dir_x, dir_y, output ready);
endinterface

interface vap_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] vel_fwd;
  logic signed [7:0] vel_side;
  logic              done_res;
  logic              timed_out;

  modport source (output valid, vel_fwd, vel_side, done_res, timed_out, input ready);
  modport sink (input valid, vel_fwd, vel_side, done_res, timed_out, output ready);
endinterface

// File: hw/rtl/vap_axis_vel.sv
// velocity of one axis: negated error times q8.8 gain, clamped and dead-zoned
// depends on vap_pkg
module vap_axis_vel (
  input  logic signed [vap_pkg::ErrBits-1:0] err_i,
  input  vap_pkg::cfg_t                      cfg_i,
  output logic signed [7:0]                  vel_o,
  output logic                               aligned_o
);
  import vap_pkg::*;

  logic [ErrBits-1:0] mag;
  logic [ProdW-1:0]   prod;
  logic [ProdW-9:0]   scaled;
  logic [6:0]         clamped;
  logic               positive;

  assign mag       = err_i[ErrBits-1] ? (~unsigned'(err_i) + 1'b1) : unsigned'(err_i);
  assign aligned_o = CmpW'(mag) < CmpW'(cfg_i.dead_zone);
  assign prod      = ProdW'(mag) * ProdW'(cfg_i.gain_q8);
  assign scaled    = prod[ProdW-1:8];
  assign clamped   = (scaled > (ProdW-8)'(cfg_i.max_speed)) ? cfg_i.max_speed : scaled[6:0];
  assign positive  = !err_i[ErrBits-1] && (err_i != '0);

  always_comb begin
    if (aligned_o) begin
      vel_o = '0;
    end else if (positive) begin
      vel_o = -signed'({1'b0, clamped});
    end else begin
      vel_o = signed'({1'b0, clamped});
    end
  end

endmodule

// File: hw/rtl/visual_align_p_controller.sv
// top level of the two-axis proportional alignment controller
// depends on vap_pkg, vap_if, vap_axis_vel and visual_align_p_controller_assert.svh
//
// Takes one request per clock cycle: measurement, control tick, start or stop.
// A request is registered, then the controller state and the axis velocity
// unit (one 12x16 multiply per axis) settle it combinationally and, for a
// stop or tick, load the result register; a new request is taken every cycle
// while the result register is free or being drained. Settings are to be written
// over the apb port only while no request is pending; the block does not check.
`include "visual_align_p_controller_assert.svh"

module visual_align_p_controller (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  vap_in_if.sink                   in_i,
  vap_out_if.source                out_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [vap_pkg::AddrW-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import vap_pkg::*;

  cfg_t cfg_q, cfg_d;
  reg_e reg_idx;
  logic cfg_wr;

  logic                      s1_valid_q, s1_valid_d;
  op_e                       s1_op_q;
  logic signed [ErrBits-1:0] s1_err_x_q, s1_err_y_q;
  logic [1:0]                s1_dir_x_q, s1_dir_y_q;
  logic                      s1_adv;

  logic                      active_q, active_d;
  logic [7:0]                upd_cnt_q, upd_cnt_d;
  logic                      lost_q, lost_d;
  logic signed [ErrBits-1:0] held_x_q, held_x_d;
  logic signed [ErrBits-1:0] held_y_q, held_y_d;
  logic [15:0]               tick_cnt_q, tick_cnt_d;
  logic [15:0]               tick_next;

  logic              res_valid;
  logic signed [7:0] res_fwd, res_side;
  logic              res_done, res_to;

  logic              out_valid_q, out_valid_d;
  logic signed [7:0] out_fwd_q, out_side_q;
  logic              out_done_q, out_to_q;

  logic signed [7:0] vel_x, vel_y;
  logic              aligned_x, aligned_y;

  // apb register file
  assign pready  = 1'b1;
  assign reg_idx = reg_e'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_idx)
        RegGain:    cfg_d.gain_q8        = pwdata[15:0];
        RegDeadZn:  cfg_d.dead_zone      = pwdata[DzBits-1:0];
        RegMaxSpd:  cfg_d.max_speed      = pwdata[6:0];
        RegWarmup:  cfg_d.warmup_updates = pwdata[7:0];
        RegTimeout: cfg_d.timeout_ticks  = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegGain:    prdata = 32'(cfg_q.gain_q8);
      RegDeadZn:  prdata = 32'(cfg_q.dead_zone);
      RegMaxSpd:  prdata = 32'(cfg_q.max_speed);
      RegWarmup:  prdata = 32'(cfg_q.warmup_updates);
      RegTimeout: prdata = 32'(cfg_q.timeout_ticks);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_q8        <= GainRst;
      cfg_q.dead_zone      <= DeadZnRst;
      cfg_q.max_speed      <= MaxSpdRst;
      cfg_q.warmup_updates <= WarmupRst;
      cfg_q.timeout_ticks  <= TimeoutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // input register
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign s1_valid_d = in_i.valid ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_i.ready ? s1_valid_d : s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_op_q    <= op_e'(in_i.opcode);
      s1_err_x_q <= in_i.err_x;
      s1_err_y_q <= in_i.err_y;
      s1_dir_x_q <= in_i.dir_x;
      s1_dir_y_q <= in_i.dir_y;
    end
  end

  // axis velocity units
  vap_axis_vel u_axis_x (
    .err_i     (held_x_q),
    .cfg_i     (cfg_q),
    .vel_o     (vel_x),
    .aligned_o (aligned_x)
  );

  vap_axis_vel u_axis_y (
    .err_i     (held_y_q),
    .cfg_i     (cfg_q),
    .vel_o     (vel_y),
    .aligned_o (aligned_y)
  );

  assign tick_next = (tick_cnt_q != TickMax) ? tick_cnt_q + 16'd1 : tick_cnt_q;

  // controller update
  always_comb begin
    active_d   = active_q;
    upd_cnt_d  = upd_cnt_q;
    lost_d     = lost_q;
    held_x_d   = held_x_q;
    held_y_d   = held_y_q;
    tick_cnt_d = tick_cnt_q;
    res_valid  = 1'b0;
    res_fwd    = '0;
    res_side   = '0;
    res_done   = 1'b0;
    res_to     = 1'b0;
    if (s1_adv) begin
      case (s1_op_q)
        OpMeas: begin
          if (upd_cnt_q != CountMax) begin
            upd_cnt_d = upd_cnt_q + 8'd1;
          end
          if (s1_dir_x_q == LostCode && s1_dir_y_q == LostCode) begin
            lost_d = 1'b1;
          end else begin
            lost_d   = 1'b0;
            held_x_d = s1_err_x_q;
            held_y_d = s1_err_y_q;
          end
        end
        OpStart: begin
          held_x_d   = '0;
          held_y_d   = '0;
          upd_cnt_d  = '0;
          lost_d     = 1'b0;
          tick_cnt_d = '0;
          active_d   = 1'b1;
        end
        OpStop: begin
          active_d  = 1'b0;
          res_valid = 1'b1;
        end
        OpTick: begin
          if (active_q) begin
            tick_cnt_d = tick_next;
            if (tick_next >= cfg_q.timeout_ticks) begin
              active_d  = 1'b0;
              res_valid = 1'b1;
              res_done  = 1'b1;
              res_to    = 1'b1;
            end else if (upd_cnt_q < cfg_q.warmup_updates) begin
              res_valid = 1'b0;
            end else if (lost_q) begin
              res_valid = 1'b1;
            end else if (aligned_x && aligned_y) begin
              active_d  = 1'b0;
              res_valid = 1'b1;
              res_done  = 1'b1;
            end else begin
              res_valid = 1'b1;
              res_fwd   = vel_y;
              res_side  = vel_x;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      upd_cnt_q  <= '0;
      lost_q     <= 1'b0;
      held_x_q   <= '0;
      held_y_q   <= '0;
      tick_cnt_q <= '0;
    end else begin
      active_q   <= active_d;
      upd_cnt_q  <= upd_cnt_d;
      lost_q     <= lost_d;
      held_x_q   <= held_x_d;
      held_y_q   <= held_y_d;
      tick_cnt_q <= tick_cnt_d;
    end
  end

  // result register
  assign out_valid_d = (s1_adv && res_valid) ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && res_valid) begin
      out_fwd_q  <= res_fwd;
      out_side_q <= res_side;
      out_done_q <= res_done;
      out_to_q   <= res_to;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.vel_fwd   = out_fwd_q;
  assign out_o.vel_side  = out_side_q;
  assign out_o.done_res  = out_done_q;
  assign out_o.timed_out = out_to_q;

  `VAP_ASSERT_NEXT(a_start_arms, clk_i, rst_ni, s1_adv && s1_op_q == OpStart, active_q && tick_cnt_q == '0 && upd_cnt_q == '0)
  `VAP_ASSERT_NEXT(a_stop_result, clk_i, rst_ni, s1_adv && s1_op_q == OpStop, out_valid_q && !active_q && !out_done_q && out_fwd_q == '0)
  `VAP_ASSERT(a_timeout_ends, clk_i, rst_ni, !(out_valid_q && out_to_q) || (out_done_q && out_fwd_q == '0 && out_side_q == '0))
  `VAP_ASSERT_NEXT(a_idle_tick, clk_i, rst_ni, s1_adv && s1_op_q == OpTick && !active_q, $stable(tick_cnt_q) && !active_q)

endmodule
